### rtl/core/lmfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED matrix frame refresh - shared types and constants
// Item formats, command queue entry, sequencer states and address helpers.
// ----------------------------------------------------------------------------
package lmfr_pkg;

    localparam int MODULES_PER_BAND = 8;
    localparam int NUM_MODULES      = 16;
    localparam int FB_BYTES         = NUM_MODULES * 8;
    localparam int FB_AW            = $clog2(FB_BYTES);
    localparam int PIXEL_ROWS       = 16;
    localparam int BAND_ROWS        = 8;
    localparam int PIXEL_COLS       = MODULES_PER_BAND * 8;
    localparam int STEP_W           = $clog2(NUM_MODULES);
    localparam int LK_W             = 12;   // room for any address sum before the range check
    localparam int OUTQ_DEPTH       = 4;
    localparam int OQ_PTR_W         = $clog2(OUTQ_DEPTH);
    localparam int OQ_CNT_W         = $clog2(OUTQ_DEPTH + 1);

    localparam logic [1:0] FUNC_PIXEL   = 2'd0;
    localparam logic [1:0] FUNC_REFRESH = 2'd1;
    localparam logic [1:0] FUNC_BCAST   = 2'd2;

    localparam logic [7:0] PIXEL_MSB_MASK = 8'h80;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
        logic       pixel_on;
        logic [2:0] row_index;
        logic [3:0] cmd_register;
        logic [7:0] cmd_value;
    } t_in_item;

    typedef struct packed {
        logic [15:0] spi_word;
        logic [3:0]  module_index;
        logic        last_of_burst;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_PIXEL,
        OP_REFRESH,
        OP_BCAST
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [FB_AW-1:0] addr;
        logic [7:0]       mask;
        logic             on;
        logic [2:0]       row;
        logic [15:0]      word;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BURST,
        ST_PIX_RD,
        ST_PIX_WR
    } t_back_state;

    typedef struct packed {
        logic             oob;
        logic [FB_AW-1:0] addr;
    } t_fb_lookup;

    // Buffer byte feeding chain position step during a refresh of digit row.
    function automatic t_fb_lookup refresh_lookup(logic [2:0] row, logic [STEP_W-1:0] step);
        logic [LK_W-1:0] prow;
        logic [LK_W-1:0] col;
        logic [LK_W-1:0] full_addr;
        t_fb_lookup      res;
        if (LK_W'(step) < LK_W'(MODULES_PER_BAND)) begin
            prow = LK_W'(row) + LK_W'(BAND_ROWS);
            col  = LK_W'(step);
        end else begin
            prow = LK_W'(row);
            col  = LK_W'(step) - LK_W'(MODULES_PER_BAND);
        end
        full_addr = prow * LK_W'(MODULES_PER_BAND) + col;
        res.oob   = full_addr >= LK_W'(FB_BYTES);
        res.addr  = full_addr[FB_AW-1:0];
        return res;
    endfunction

endpackage
`default_nettype wire

### rtl/core/lmfr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED matrix frame refresh - command front end
// Decodes input items into queue commands; drops no-op items.
// ----------------------------------------------------------------------------
module lmfr_front (
    input  var lmfr_pkg::t_in_item i_item,
    output var lmfr_pkg::t_cmd     o_cmd,
    output logic                   o_keep
);
    import lmfr_pkg::*;

    logic [LK_W-1:0] pix_addr;
    logic            pix_ok;

    always_comb begin
        pix_addr = LK_W'(i_item.pixel_y) * LK_W'(MODULES_PER_BAND)
                 + LK_W'(i_item.pixel_x[7:3]);
        pix_ok   = (LK_W'(i_item.pixel_x) < LK_W'(PIXEL_COLS))
                && (LK_W'(i_item.pixel_y) < LK_W'(PIXEL_ROWS))
                && (pix_addr < LK_W'(FB_BYTES));

        o_cmd.op   = OP_PIXEL;
        o_cmd.addr = pix_addr[FB_AW-1:0];
        o_cmd.mask = PIXEL_MSB_MASK >> i_item.pixel_x[2:0];
        o_cmd.on   = i_item.pixel_on;
        o_cmd.row  = i_item.row_index;
        o_cmd.word = 16'h0000;
        o_keep     = 1'b0;

        unique case (i_item.func)
            FUNC_PIXEL: begin
                o_keep = pix_ok;
            end
            FUNC_REFRESH: begin
                o_cmd.op   = OP_REFRESH;
                o_cmd.word = {8'(i_item.row_index) + 8'd1, 8'h00};
                o_keep     = 1'b1;
            end
            FUNC_BCAST: begin
                o_cmd.op   = OP_BCAST;
                o_cmd.word = {4'h0, i_item.cmd_register, i_item.cmd_value};
                o_keep     = 1'b1;
            end
            default: begin
                o_keep = 1'b0;   // unused selector
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/core/lmfr_cmdq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED matrix frame refresh - command queue
// Two-entry queue decoupling the front end from the sequencer.
// ----------------------------------------------------------------------------
module lmfr_cmdq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  var lmfr_pkg::t_cmd   i_cmd,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output var lmfr_pkg::t_cmd   o_cmd
);
    import lmfr_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_q[r_rp];

    always_comb begin
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
        n_wp    = do_push ? ~r_wp : r_wp;
        n_rp    = do_pop ? ~r_rp : r_rp;
        n_cnt   = r_cnt + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

### rtl/core/lmfr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED matrix frame refresh - sequencer
// Frame buffer, pixel read-modify-write, word bursts and result queue.
// ----------------------------------------------------------------------------
module lmfr_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  var lmfr_pkg::t_cmd      i_cmd,
    input  logic                    i_cmd_empty,
    output logic                    o_cmd_pop,
    input  logic                    i_pop,
    output logic                    o_empty,
    output var lmfr_pkg::t_out_item o_item
);
    import lmfr_pkg::*;

    // frame buffer; bytes never written read as zero via the valid bits
    logic [7:0]          mem [FB_BYTES];
    logic [FB_BYTES-1:0] r_valid;
    logic [7:0]          r_rd_data;
    logic                r_rd_vld;
    logic [FB_AW-1:0]    mem_addr;
    logic                mem_we;
    logic [7:0]          mem_wdata;
    logic [7:0]          mem_q;

    t_back_state         r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    t_cmd                r_cmd, n_cmd;
    t_fb_lookup          lk;
    logic                issue;
    logic                step_last;

    // read stage between address issue and result queue
    logic                r_p_valid;
    logic [15:0]         r_p_word, n_p_word;
    logic                r_p_use_mem, n_p_use_mem;
    logic [3:0]          r_p_index, n_p_index;
    logic                r_p_last, n_p_last;

    t_out_item           r_oq [OUTQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wp, r_rp;
    logic [OQ_CNT_W-1:0] r_cnt;
    logic                oq_pop;
    t_out_item           oq_in;

    assign mem_q     = r_rd_vld ? r_rd_data : 8'h00;
    assign step_last = (r_step == STEP_W'(NUM_MODULES - 1));

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_cmd       = r_cmd;
        o_cmd_pop   = 1'b0;
        mem_addr    = r_cmd.addr;
        mem_we      = 1'b0;
        mem_wdata   = r_cmd.on ? (mem_q | r_cmd.mask) : (mem_q & ~r_cmd.mask);
        lk          = refresh_lookup(r_cmd.row, r_step);
        issue       = 1'b0;
        n_p_word    = r_cmd.word;
        n_p_use_mem = (r_cmd.op == OP_REFRESH) && !lk.oob;
        n_p_index   = 4'(r_step);
        n_p_last    = step_last;

        unique case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_step    = '0;
                    n_state   = (i_cmd.op == OP_PIXEL) ? ST_PIX_RD : ST_BURST;
                end
            end
            ST_BURST: begin
                mem_addr = lk.addr;
                issue    = ({1'b0, r_cnt} + {{OQ_CNT_W{1'b0}}, r_p_valid})
                         < (OQ_CNT_W + 1)'(OUTQ_DEPTH);
                if (issue) begin
                    n_step = r_step + 1'b1;
                    if (step_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_PIX_RD: begin
                n_state = ST_PIX_WR;
            end
            ST_PIX_WR: begin
                mem_we  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= '0;
            r_p_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_p_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        if (issue) begin
            r_p_word    <= n_p_word;
            r_p_use_mem <= n_p_use_mem;
            r_p_index   <= n_p_index;
            r_p_last    <= n_p_last;
        end
    end

    // single-port buffer, read-first
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        r_rd_data <= mem[mem_addr];
        r_rd_vld  <= r_valid[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (mem_we) begin
            r_valid[mem_addr] <= 1'b1;
        end
    end

    // result queue
    always_comb begin
        oq_in.spi_word      = r_p_word | {8'h00, r_p_use_mem ? mem_q : 8'h00};
        oq_in.module_index  = r_p_index;
        oq_in.last_of_burst = r_p_last;
        oq_pop              = i_pop && !o_empty;
    end

    assign o_empty = (r_cnt == '0);
    assign o_item  = r_oq[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (r_p_valid) begin
                r_wp <= r_wp + 1'b1;
            end
            if (oq_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + OQ_CNT_W'(r_p_valid) - OQ_CNT_W'(oq_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p_valid) begin
            r_oq[r_wp] <= oq_in;
        end
    end

    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= OQ_CNT_W'(OUTQ_DEPTH))
        else $error("result queue count beyond depth");

    a_oq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid |-> (r_cnt < OQ_CNT_W'(OUTQ_DEPTH)))
        else $error("read stage transfer into full result queue");

    a_rmw_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PIX_WR) |-> ($past(r_state) == ST_PIX_RD))
        else $error("pixel write without preceding read");

    a_burst_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && !i_cmd_empty && i_cmd.op != OP_PIXEL)
            |=> (r_state == ST_BURST && r_step == '0))
        else $error("burst did not start at first chain position");

endmodule
`default_nettype wire

### rtl/core/led_matrix_frame_refresh.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: a refresh or broadcast passes the command queue, sequencer pickup, buffer read
//   and result queue before its first word shows; a pixel write passes the queue, pickup and read state.
// Rate: after the pickup state a refresh/broadcast sends one word per cycle out of the
//   single-port buffer while the result queue has room; a pixel write does read-modify-write on that same port.
// Reset: synchronous; clears the queues and all 128 byte-valid flags together, so the
//   frame reads as all dark right away, no clearing pass.
// ----------------------------------------------------------------------------
// LED matrix frame refresh
// Frame buffer for a chain of 8x8 LED driver modules with row refresh and
// broadcast command bursts.
// ----------------------------------------------------------------------------
module led_matrix_frame_refresh (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input queue side: transfer when push && !full
    input  logic                    push,
    output logic                    full,
    input  var lmfr_pkg::t_in_item  i_in_item,
    // result queue side: transfer when pop && !empty
    output logic                    empty,
    input  logic                    pop,
    output var lmfr_pkg::t_out_item o_out_item
);
    import lmfr_pkg::*;

    t_cmd front_cmd;
    logic front_keep;
    t_cmd q_cmd;
    logic q_full;
    logic q_empty;
    logic q_pop;

    // Front end: decode and drop items that produce nothing (func 3,
    // pixels outside the frame). Those still count as a transfer.
    lmfr_front u_front (
        .i_item (i_in_item),
        .o_cmd  (front_cmd),
        .o_keep (front_keep)
    );

    // Input is held off only while the command queue is full.
    assign full = q_full;

    lmfr_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && front_keep),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    // Back end: owns the frame buffer, walks the chain positions and
    // feeds a small result queue so the consumer can stall freely.
    lmfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_empty (q_empty),
        .o_cmd_pop   (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_item      (o_out_item)
    );

endmodule
`default_nettype wire
